/* design/rhwf_pkg.sv */
// Package for the right-hand wall follower: item types, codes and fixed sizes.
// Depends on nothing; used by rhwf_walker and the top level.
`timescale 1ns / 1ps

package rhwf_pkg;

    localparam int GRID_MAX  = 32;
    localparam int COORD_W   = 5;
    localparam int CELLS     = GRID_MAX * GRID_MAX;
    localparam int ADDR_W    = 2 * COORD_W;
    localparam int COUNT_W   = ADDR_W + 1;
    localparam int CNT20_W   = 20;
    localparam int CFG_IDX_W = 3;
    localparam logic [CNT20_W-1:0] SAT20 = '1;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_SOLVE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_LIMIT = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_ROW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_COL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_ROW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_COL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIM  = 3'd5;

    typedef struct packed {
        logic [1:0]         kind;
        logic [COORD_W-1:0] cell_row;
        logic [COORD_W-1:0] cell_col;
        logic               cell_open;
        logic [ADDR_W-1:0]  path_index;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [COORD_W-1:0] path_row;
        logic [COORD_W-1:0] path_col;
        logic [COUNT_W-1:0] path_length;
        logic [CNT20_W-1:0] moves;
        logic [CNT20_W-1:0] dead_ends;
        logic [COUNT_W-1:0] visited_count;
    } rsp_t;

    typedef struct packed {
        logic [5:0]         grid_size;
        logic [COORD_W-1:0] start_row;
        logic [COORD_W-1:0] start_col;
        logic [COORD_W-1:0] goal_row;
        logic [COORD_W-1:0] goal_col;
        logic [CNT20_W-1:0] iteration_limit;
    } cfg_t;

    // top -> walker
    typedef struct packed {
        logic start;
        logic take;
    } ctl_t;

    // walker -> top
    typedef struct packed {
        logic idle;
        logic done;
    } sts_t;

endpackage

/* design/rhwf_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module rhwf_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/rhwf_walker.sv */
// Walk engine: maze, seen map and path stack memories with the solve sequencer.
// Depends on rhwf_pkg and rhwf_ram.
`timescale 1ns / 1ps

module rhwf_walker
    import rhwf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  ctl_t ctl,
    input  req_t item,
    input  cfg_t cfg,
    output sts_t sts,
    output rsp_t result
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CLR      = 4'd1;
    localparam logic [3:0] S_INIT     = 4'd2;
    localparam logic [3:0] S_LOOP     = 4'd3;
    localparam logic [3:0] S_NB_ISS   = 4'd4;
    localparam logic [3:0] S_NB_CAP   = 4'd5;
    localparam logic [3:0] S_DECIDE   = 4'd6;
    localparam logic [3:0] S_SEEN_RD  = 4'd7;
    localparam logic [3:0] S_SEEN_CHK = 4'd8;
    localparam logic [3:0] S_TRIM     = 4'd9;
    localparam logic [3:0] S_TRIM_CHK = 4'd10;
    localparam logic [3:0] S_RD_WAIT  = 4'd11;
    localparam logic [3:0] S_DONE     = 4'd12;

    logic [3:0]         state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [1:0]         heading_reg, heading_next;
    logic [COORD_W-1:0] row_reg, row_next, col_reg, col_next;
    logic [CNT20_W-1:0] moves_reg, moves_next, dead_reg, dead_next, iter_reg, iter_next;
    logic [COUNT_W-1:0] seen_tot_reg, seen_tot_next;
    logic [ADDR_W-1:0]  clr_reg, clr_next;
    logic [1:0]         k_reg, k_next;
    logic               inb_reg, inb_next, intr_cur;
    logic [3:0]         open_reg, open_next, intr_reg, intr_next;
    logic [1:0]         status_reg, status_next;
    logic [COORD_W-1:0] prow_reg, prow_next, pcol_reg, pcol_next;

    // memory ports
    logic               maze_we, seen_we, seen_wd, stk_we;
    logic [ADDR_W-1:0]  maze_ra, seen_wa, seen_ra, stk_wa, stk_ra, stk_wd;
    logic               maze_rd, seen_rd;
    logic [ADDR_W-1:0]  stk_rd;

    rhwf_ram #(.WIDTH(1), .DEPTH(CELLS)) u_maze (
        .clk(clk), .we(maze_we), .waddr({item.cell_row, item.cell_col}),
        .wdata(item.cell_open), .raddr(maze_ra), .rdata(maze_rd)
    );

    rhwf_ram #(.WIDTH(1), .DEPTH(CELLS)) u_seen (
        .clk(clk), .we(seen_we), .waddr(seen_wa),
        .wdata(seen_wd), .raddr(seen_ra), .rdata(seen_rd)
    );

    rhwf_ram #(.WIDTH(ADDR_W), .DEPTH(CELLS)) u_stack (
        .clk(clk), .we(stk_we), .waddr(stk_wa),
        .wdata(stk_wd), .raddr(stk_ra), .rdata(stk_rd)
    );

    logic [5:0] n_eff, n_m2;
    assign n_eff = (cfg.grid_size < 6'd3) ? 6'd3 :
                   (cfg.grid_size > 6'(GRID_MAX)) ? 6'(GRID_MAX) : cfg.grid_size;
    assign n_m2  = n_eff - 6'd2;

    // neighbour k of the current cell
    logic [5:0] nr, nc;
    always_comb
    begin
        nr       = {1'b0, row_reg};
        nc       = {1'b0, col_reg};
        inb_next = 1'b0;
        case (k_reg)
            2'd0:
            begin
                nr       = {1'b0, row_reg} - 6'd1;
                inb_next = (row_reg != '0);
            end
            2'd1:
            begin
                nc       = {1'b0, col_reg} + 6'd1;
                inb_next = (nc < n_eff);
            end
            2'd2:
            begin
                nr       = {1'b0, row_reg} + 6'd1;
                inb_next = (nr < n_eff);
            end
            default:
            begin
                nc       = {1'b0, col_reg} - 6'd1;
                inb_next = (col_reg != '0);
            end
        endcase
        intr_cur = inb_next && (nr >= 6'd1) && (nr <= n_m2) && (nc >= 6'd1) && (nc <= n_m2);
    end

    logic [1:0]         d_right, d_step;
    logic [2:0]         open_cnt;
    logic [ADDR_W-1:0]  here_idx;
    assign d_right  = heading_reg + 2'd1;
    assign open_cnt = 3'($countones(open_reg & intr_reg));
    assign here_idx = {row_reg, col_reg};

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        heading_next  = heading_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        moves_next    = moves_reg;
        dead_next     = dead_reg;
        iter_next     = iter_reg;
        seen_tot_next = seen_tot_reg;
        clr_next      = clr_reg;
        k_next        = k_reg;
        open_next     = open_reg;
        intr_next     = intr_reg;
        status_next   = status_reg;
        prow_next     = prow_reg;
        pcol_next     = pcol_reg;
        d_step        = heading_reg;
        maze_we       = 1'b0;
        maze_ra       = {nr[COORD_W-1:0], nc[COORD_W-1:0]};
        seen_we       = 1'b0;
        seen_wa       = clr_reg;
        seen_wd       = 1'b0;
        seen_ra       = here_idx;
        stk_we        = 1'b0;
        stk_wa        = count_reg[ADDR_W-1:0];
        stk_wd        = here_idx;
        stk_ra        = item.path_index;

        case (state_reg)
            S_IDLE:
            begin
                if (ctl.start)
                begin
                    status_next = STATUS_OK;
                    prow_next   = '0;
                    pcol_next   = '0;
                    state_next  = S_DONE;
                    case (item.kind)
                        KIND_LOAD:
                        begin
                            maze_we = 1'b1;
                        end
                        KIND_SOLVE:
                        begin
                            count_next    = '0;
                            heading_next  = 2'd1;
                            moves_next    = '0;
                            dead_next     = '0;
                            iter_next     = '0;
                            seen_tot_next = COUNT_W'(1);
                            row_next      = cfg.start_row;
                            col_next      = cfg.start_col;
                            clr_next      = '0;
                            state_next    = S_CLR;
                        end
                        KIND_READ:
                        begin
                            if ({1'b0, item.path_index} >= count_reg)
                            begin
                                status_next = STATUS_RANGE;
                            end
                            else
                            begin
                                state_next = S_RD_WAIT;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_RD_WAIT:
            begin
                prow_next  = stk_rd[ADDR_W-1:COORD_W];
                pcol_next  = stk_rd[COORD_W-1:0];
                state_next = S_DONE;
            end
            S_CLR:
            begin
                seen_we  = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(CELLS - 1))
                begin
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                stk_we     = 1'b1;
                stk_wa     = '0;
                count_next = COUNT_W'(1);
                if ({1'b0, row_reg} >= n_eff || {1'b0, col_reg} >= n_eff)
                begin
                    stk_wd      = '0;
                    status_next = (row_reg == cfg.goal_row && col_reg == cfg.goal_col)
                                  ? STATUS_OK : STATUS_LIMIT;
                    prow_next   = row_reg;
                    pcol_next   = col_reg;
                    state_next  = S_DONE;
                end
                else
                begin
                    seen_we    = 1'b1;
                    seen_wa    = here_idx;
                    seen_wd    = 1'b1;
                    state_next = S_LOOP;
                end
            end
            S_LOOP:
            begin
                prow_next = row_reg;
                pcol_next = col_reg;
                if (row_reg == cfg.goal_row && col_reg == cfg.goal_col)
                begin
                    status_next = STATUS_OK;
                    state_next  = S_DONE;
                end
                else if (iter_reg >= cfg.iteration_limit)
                begin
                    status_next = STATUS_LIMIT;
                    state_next  = S_DONE;
                end
                else
                begin
                    iter_next  = iter_reg + 1'b1;
                    k_next     = '0;
                    state_next = S_NB_ISS;
                end
            end
            S_NB_ISS:
            begin
                // read address is the neighbour; hold flags for capture
                intr_next[k_reg] = intr_cur;
                state_next       = S_NB_CAP;
            end
            S_NB_CAP:
            begin
                open_next[k_reg] = inb_reg & maze_rd;
                intr_next[k_reg] = intr_reg[k_reg] & maze_rd;
                k_next           = k_reg + 2'd1;
                state_next       = (k_reg == 2'd3) ? S_DECIDE : S_NB_ISS;
            end
            S_DECIDE:
            begin
                if (open_cnt == 3'd1 && dead_reg != SAT20)
                begin
                    dead_next = dead_reg + 1'b1;
                end
                if (open_reg[d_right] || open_reg[heading_reg])
                begin
                    d_step       = open_reg[d_right] ? d_right : heading_reg;
                    heading_next = d_step;
                    case (d_step)
                        2'd0:    row_next = row_reg - 1'b1;
                        2'd1:    col_next = col_reg + 1'b1;
                        2'd2:    row_next = row_reg + 1'b1;
                        default: col_next = col_reg - 1'b1;
                    endcase
                    if (moves_reg != SAT20)
                    begin
                        moves_next = moves_reg + 1'b1;
                    end
                    state_next = S_SEEN_RD;
                end
                else
                begin
                    heading_next = heading_reg + 2'd2;
                    state_next   = S_LOOP;
                end
            end
            S_SEEN_RD:
            begin
                state_next = S_SEEN_CHK;
            end
            S_SEEN_CHK:
            begin
                if (seen_rd)
                begin
                    state_next = S_TRIM;
                end
                else
                begin
                    seen_we       = 1'b1;
                    seen_wa       = here_idx;
                    seen_wd       = 1'b1;
                    seen_tot_next = seen_tot_reg + 1'b1;
                    if (count_reg < COUNT_W'(CELLS))
                    begin
                        stk_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    state_next = S_LOOP;
                end
            end
            S_TRIM:
            begin
                stk_ra = count_reg[ADDR_W-1:0] - 1'b1;
                if (count_reg == '0)
                begin
                    stk_we     = 1'b1;
                    count_next = COUNT_W'(1);
                    state_next = S_LOOP;
                end
                else
                begin
                    state_next = S_TRIM_CHK;
                end
            end
            S_TRIM_CHK:
            begin
                if (stk_rd == here_idx)
                begin
                    state_next = S_LOOP;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_TRIM;
                end
            end
            S_DONE:
            begin
                if (ctl.take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            heading_reg  <= 2'd1;
            row_reg      <= '0;
            col_reg      <= '0;
            moves_reg    <= '0;
            dead_reg     <= '0;
            seen_tot_reg <= '0;
            iter_reg     <= '0;
            clr_reg      <= '0;
            k_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            heading_reg  <= heading_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            moves_reg    <= moves_next;
            dead_reg     <= dead_next;
            seen_tot_reg <= seen_tot_next;
            iter_reg     <= iter_next;
            clr_reg      <= clr_next;
            k_reg        <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inb_reg    <= inb_next;
        open_reg   <= open_next;
        intr_reg   <= intr_next;
        status_reg <= status_next;
        prow_reg   <= prow_next;
        pcol_reg   <= pcol_next;
    end

    assign sts.idle = (state_reg == S_IDLE);
    assign sts.done = (state_reg == S_DONE);

    assign result.status        = status_reg;
    assign result.path_row      = prow_reg;
    assign result.path_col      = pcol_reg;
    assign result.path_length   = count_reg;
    assign result.moves         = moves_reg;
    assign result.dead_ends     = dead_reg;
    assign result.visited_count = seen_tot_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(CELLS))
        else $error("path stack count beyond depth");

    a_clear_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLR |=> state_reg == S_CLR || state_reg == S_INIT)
        else $error("seen map clear left early");

    a_dead_mono: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |=> dead_reg >= $past(dead_reg))
        else $error("dead-end count fell during a walk");

    a_trim_pop: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_TRIM_CHK && stk_rd != here_idx |=> count_reg == $past(count_reg) - 1'b1)
        else $error("trim did not pop");
`endif

endmodule

/* design/right_hand_wall_follower.sv */
// Top level of the right-hand wall follower: configuration registers,
// request/response handshake and the output register. Depends on rhwf_pkg, rhwf_walker.
`timescale 1ns / 1ps

// The block takes one request beat at a time and answers each with exactly one
// response beat. A load writes one maze cell; a path read returns one stored
// path entry or a range status. A solve first clears the 1024-entry seen map
// one entry a cycle, then runs walk iterations: the four neighbour reads go one
// at a time through the maze memory's read port, the walker steps right if open,
// else straight, else turns around, and a step onto a seen cell pops path entries
// back to that cell. A new request is taken as soon as the engine is idle, even
// while the previous response still waits in the output register. Configuration
// writes take effect at once and must only be made between items.
module right_hand_wall_follower
    import rhwf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CNT20_W-1:0]   wr_data,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  req_t                 req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output rsp_t                 rsp
);

    cfg_t cfg_reg;
    ctl_t ctl;
    sts_t sts;
    rsp_t result;
    rsp_t rsp_reg;
    logic rsp_valid_reg, rsp_valid_next;

    // Configuration registers; indexes past the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_size       <= 6'd32;
            cfg_reg.start_row       <= 5'd1;
            cfg_reg.start_col       <= 5'd1;
            cfg_reg.goal_row        <= 5'd30;
            cfg_reg.goal_col        <= 5'd30;
            cfg_reg.iteration_limit <= SAT20;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_GRID_SIZE: cfg_reg.grid_size       <= wr_data[5:0];
                REG_START_ROW: cfg_reg.start_row       <= wr_data[COORD_W-1:0];
                REG_START_COL: cfg_reg.start_col       <= wr_data[COORD_W-1:0];
                REG_GOAL_ROW:  cfg_reg.goal_row        <= wr_data[COORD_W-1:0];
                REG_GOAL_COL:  cfg_reg.goal_col        <= wr_data[COORD_W-1:0];
                REG_ITER_LIM:  cfg_reg.iteration_limit <= wr_data;
                default:       cfg_reg.grid_size       <= cfg_reg.grid_size;
            endcase
        end
    end

    // Accept a request whenever the engine is idle.
    assign req_stall = !sts.idle;
    assign ctl.start = req_valid && sts.idle;

    // Move the finished result into the output register once it is free.
    assign ctl.take = sts.done && (!rsp_valid_reg || !rsp_stall);

    rhwf_walker u_walker (
        .clk(clk),
        .rst_n(rst_n),
        .ctl(ctl),
        .item(req),
        .cfg(cfg_reg),
        .sts(sts),
        .result(result)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (ctl.take)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Hold the payload while the beat is stalled.
    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
